@@ src/cmta_pkg.sv @@
// Shared types and constants for the cube-map texel address pipeline.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cmta_pkg;

	localparam int DIR_W    = 16;
	localparam int COL_W    = 10;
	localparam int OFS_W    = 20;
	localparam int CFG_W    = 11;
	localparam int MAG_W    = 16;  // |component|, 32768 fits unsigned
	localparam int UV_W     = 17;  // negated component, signed
	localparam int NUM_W    = 17;  // num + m, 0..65536
	localparam int DIV_W    = 17;  // 2*m

	localparam logic [1:0]       ADDR_FACE_SIZE  = 2'd0;
	localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 11'd512;

	typedef enum logic [2:0] {
		FACE_PX = 3'd0,
		FACE_NX = 3'd1,
		FACE_PY = 3'd2,
		FACE_NY = 3'd3,
		FACE_PZ = 3'd4,
		FACE_NZ = 3'd5
	} face_t;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} in_t;

	typedef struct packed {
		logic [2:0]       face_index;
		logic [COL_W-1:0] texel_col;
		logic [COL_W-1:0] texel_row;
		logic [OFS_W-1:0] texel_offset;
		logic             zero_vector;
	} out_t;

	// per-transaction tag carried down the chain
	typedef struct packed {
		face_t face;
		logic  zero;
	} ctl_t;

endpackage

`default_nettype wire

@@ src/cube_map_texel_address_top.sv @@
// Pipeline: the division chain, one cell per quotient bit, plus two front and two back stages.
// Throughput: one transaction per cycle while out_stall is low; every stage holds
// one transaction and advances when the stage after it is empty or moving.
// Reset: face_size returns to 512 and all stages empty; no clearing pass.
// Top level; depends on cmta_pkg, cmta_front, cmta_div_cell and cmta_back.
`timescale 1ns / 1ps
`default_nettype none

module cube_map_texel_address_top #(
	parameter int MAX_FACE_SIZE = 1024
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire cmta_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output cmta_pkg::out_t      out_data,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [1:0]     paddr,
	input  wire logic [31:0]    pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int SW = $clog2(MAX_FACE_SIZE + 1);
	localparam int PW = cmta_pkg::NUM_W + SW;

	logic [cmta_pkg::CFG_W-1:0] face_size_q;
	logic [31:0]   fs32;
	logic [SW-1:0] size_cl;

	assign pready = 1'b1;
	assign prdata = (paddr == cmta_pkg::ADDR_FACE_SIZE) ? 32'(face_size_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= cmta_pkg::FACE_SIZE_RESET;
		end else if (psel && penable && pwrite && paddr == cmta_pkg::ADDR_FACE_SIZE) begin
			face_size_q <= pwdata[cmta_pkg::CFG_W-1:0];
		end
	end

	// zero means 1, anything above the build maximum saturates
	always_comb begin
		fs32 = 32'(face_size_q);
		if (fs32 == 32'd0) begin
			size_cl = SW'(1);
		end else if (fs32 > 32'(MAX_FACE_SIZE)) begin
			size_cl = SW'(MAX_FACE_SIZE);
		end else begin
			size_cl = SW'(fs32);
		end
	end

	// chain links: index 0 is the front end output, index k+1 the output of cell k
	logic          vld  [SW+1];
	logic          rdy  [SW+1];
	logic [PW-1:0] ru   [SW+1];
	logic [PW-1:0] rv   [SW+1];
	logic [SW-1:0] qu   [SW+1];
	logic [SW-1:0] qv   [SW+1];
	logic [cmta_pkg::DIV_W-1:0] dd [SW+1];
	logic [SW-1:0] sz   [SW+1];
	cmta_pkg::ctl_t ctl [SW+1];
	logic          front_rdy;

	cmta_front #(
		.SW(SW),
		.PW(PW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (in_valid),
		.rdy_o  (front_rdy),
		.dat_i  (in_data),
		.size_i (size_cl),
		.vld_o  (vld[0]),
		.rdy_i  (rdy[0]),
		.pu_o   (ru[0]),
		.pv_o   (rv[0]),
		.d_o    (dd[0]),
		.size_o (sz[0]),
		.ctl_o  (ctl[0])
	);

	assign in_stall = !front_rdy;
	assign qu[0]    = '0;
	assign qv[0]    = '0;

	// MSB-first: cell k resolves quotient bit SW-1-k
	for (genvar k = 0; k < SW; k++) begin : g_cell
		cmta_div_cell #(
			.SW (SW),
			.PW (PW),
			.BIT(SW - 1 - k)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld[k]),
			.rdy_o  (rdy[k]),
			.ru_i   (ru[k]),
			.rv_i   (rv[k]),
			.qu_i   (qu[k]),
			.qv_i   (qv[k]),
			.d_i    (dd[k]),
			.size_i (sz[k]),
			.ctl_i  (ctl[k]),
			.vld_o  (vld[k+1]),
			.rdy_i  (rdy[k+1]),
			.ru_o   (ru[k+1]),
			.rv_o   (rv[k+1]),
			.qu_o   (qu[k+1]),
			.qv_o   (qv[k+1]),
			.d_o    (dd[k+1]),
			.size_o (sz[k+1]),
			.ctl_o  (ctl[k+1])
		);
	end

	cmta_back #(
		.SW(SW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_i   (vld[SW]),
		.rdy_o   (rdy[SW]),
		.qu_i    (qu[SW]),
		.qv_i    (qv[SW]),
		.size_i  (sz[SW]),
		.ctl_i   (ctl[SW]),
		.vld_o   (out_valid),
		.stall_i (out_stall),
		.dat_o   (out_data)
	);

	// remainders and divisor of the last cell are not needed downstream
	logic unused_tail;
	assign unused_tail = ^{ru[SW], rv[SW], dd[SW]};

endmodule

`default_nettype wire

@@ src/cmta_front.sv @@
// Front end: face selection (stage 1), then num+m and the scale by face size (stage 2).
// Depends on cmta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmta_front #(
	parameter int SW = 11,
	parameter int PW = 28
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_i,
	output logic                  rdy_o,
	input  wire cmta_pkg::in_t    dat_i,
	input  wire logic [SW-1:0]    size_i,
	output logic                  vld_o,
	input  wire logic             rdy_i,
	output logic [PW-1:0]         pu_o,
	output logic [PW-1:0]         pv_o,
	output logic [cmta_pkg::DIV_W-1:0] d_o,
	output logic [SW-1:0]         size_o,
	output cmta_pkg::ctl_t        ctl_o
);

	logic vld_s1, vld_s2, ld_s1, ld_s2;

	logic [cmta_pkg::MAG_W-1:0] ax, ay, az, m_c, m_s1;
	logic signed [cmta_pkg::UV_W-1:0] xe, ye, ze, u_c, v_c, u_s1, v_s1;
	cmta_pkg::face_t face_c;
	cmta_pkg::ctl_t  ctl_s1, ctl_s2;
	logic [SW-1:0]   size_s1, size_s2;

	logic signed [cmta_pkg::UV_W:0] nu_w, nv_w;
	logic [cmta_pkg::NUM_W-1:0]     nu, nv;
	logic [PW-1:0] pu_s2, pv_s2;
	logic [cmta_pkg::DIV_W-1:0] d_s2;

	assign ld_s2 = !vld_s2 || rdy_i;
	assign ld_s1 = !vld_s1 || ld_s2;
	assign rdy_o = ld_s1;

	// stage 1: magnitudes and major axis, ties to X then Y
	always_comb begin
		xe = cmta_pkg::UV_W'(dat_i.dir_x);
		ye = cmta_pkg::UV_W'(dat_i.dir_y);
		ze = cmta_pkg::UV_W'(dat_i.dir_z);
		ax = cmta_pkg::MAG_W'(dat_i.dir_x[cmta_pkg::DIR_W-1] ? -xe : xe);
		ay = cmta_pkg::MAG_W'(dat_i.dir_y[cmta_pkg::DIR_W-1] ? -ye : ye);
		az = cmta_pkg::MAG_W'(dat_i.dir_z[cmta_pkg::DIR_W-1] ? -ze : ze);
		priority if (ax >= ay && ax >= az) begin
			m_c = ax;
			v_c = -ye;
			if (dat_i.dir_x > 0) begin
				face_c = cmta_pkg::FACE_PX;
				u_c    = -ze;
			end else begin
				face_c = cmta_pkg::FACE_NX;
				u_c    = ze;
			end
		end else if (ay >= az) begin
			m_c = ay;
			u_c = xe;
			if (dat_i.dir_y > 0) begin
				face_c = cmta_pkg::FACE_PY;
				v_c    = ze;
			end else begin
				face_c = cmta_pkg::FACE_NY;
				v_c    = -ze;
			end
		end else begin
			m_c = az;
			v_c = -ye;
			if (dat_i.dir_z > 0) begin
				face_c = cmta_pkg::FACE_PZ;
				u_c    = xe;
			end else begin
				face_c = cmta_pkg::FACE_NZ;
				u_c    = -xe;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (ld_s1) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			m_s1    <= m_c;
			u_s1    <= u_c;
			v_s1    <= v_c;
			size_s1 <= size_i;
			ctl_s1.zero <= (ax == '0) && (ay == '0) && (az == '0);
			ctl_s1.face <= ((ax == '0) && (ay == '0) && (az == '0)) ?
				cmta_pkg::FACE_NX : face_c;
		end
	end

	// stage 2: n = num + m (never below zero), then n * size
	always_comb begin
		nu_w = (cmta_pkg::UV_W+1)'(u_s1) + $signed({2'b00, m_s1});
		nv_w = (cmta_pkg::UV_W+1)'(v_s1) + $signed({2'b00, m_s1});
		nu   = nu_w[cmta_pkg::UV_W] ? '0 : cmta_pkg::NUM_W'(nu_w);
		nv   = nv_w[cmta_pkg::UV_W] ? '0 : cmta_pkg::NUM_W'(nv_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (ld_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			pu_s2   <= PW'(nu) * PW'(size_s1);
			pv_s2   <= PW'(nv) * PW'(size_s1);
			d_s2    <= {m_s1, 1'b0};
			size_s2 <= size_s1;
			ctl_s2  <= ctl_s1;
		end
	end

	assign vld_o  = vld_s2;
	assign pu_o   = pu_s2;
	assign pv_o   = pv_s2;
	assign d_o    = d_s2;
	assign size_o = size_s2;
	assign ctl_o  = ctl_s2;

endmodule

`default_nettype wire

@@ src/cmta_div_cell.sv @@
// One restoring-division cell: resolves quotient bit BIT for both lanes and registers it.
// Depends on cmta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmta_div_cell #(
	parameter int SW  = 11,
	parameter int PW  = 28,
	parameter int BIT = 0
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             vld_i,
	output logic                  rdy_o,
	input  wire logic [PW-1:0]    ru_i,
	input  wire logic [PW-1:0]    rv_i,
	input  wire logic [SW-1:0]    qu_i,
	input  wire logic [SW-1:0]    qv_i,
	input  wire logic [cmta_pkg::DIV_W-1:0] d_i,
	input  wire logic [SW-1:0]    size_i,
	input  wire cmta_pkg::ctl_t   ctl_i,
	output logic                  vld_o,
	input  wire logic             rdy_i,
	output logic [PW-1:0]         ru_o,
	output logic [PW-1:0]         rv_o,
	output logic [SW-1:0]         qu_o,
	output logic [SW-1:0]         qv_o,
	output logic [cmta_pkg::DIV_W-1:0] d_o,
	output logic [SW-1:0]         size_o,
	output cmta_pkg::ctl_t        ctl_o
);

	logic          vld_q, ld;
	logic [PW-1:0] trial, ru_q, rv_q;
	logic          ge_u, ge_v;
	logic [SW-1:0] qu_c, qv_c, qu_q, qv_q;
	logic [cmta_pkg::DIV_W-1:0] d_q;
	logic [SW-1:0] size_q;
	cmta_pkg::ctl_t ctl_q;

	assign ld    = !vld_q || rdy_i;
	assign rdy_o = ld;

	always_comb begin
		trial = PW'(d_i) << BIT;
		ge_u  = ru_i >= trial;
		ge_v  = rv_i >= trial;
		qu_c  = qu_i;
		qv_c  = qv_i;
		qu_c[BIT] = ge_u;
		qv_c[BIT] = ge_v;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ld) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ru_q   <= ge_u ? ru_i - trial : ru_i;
			rv_q   <= ge_v ? rv_i - trial : rv_i;
			qu_q   <= qu_c;
			qv_q   <= qv_c;
			d_q    <= d_i;
			size_q <= size_i;
			ctl_q  <= ctl_i;
		end
	end

	assign vld_o  = vld_q;
	assign ru_o   = ru_q;
	assign rv_o   = rv_q;
	assign qu_o   = qu_q;
	assign qv_o   = qv_q;
	assign d_o    = d_q;
	assign size_o = size_q;
	assign ctl_o  = ctl_q;

endmodule

`default_nettype wire

@@ src/cmta_back.sv @@
// Back end: clamp to size-1 (stage 1), then row*size+col into the output register (stage 2).
// Depends on cmta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmta_back #(
	parameter int SW = 11
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            vld_i,
	output logic                 rdy_o,
	input  wire logic [SW-1:0]   qu_i,
	input  wire logic [SW-1:0]   qv_i,
	input  wire logic [SW-1:0]   size_i,
	input  wire cmta_pkg::ctl_t  ctl_i,
	output logic                 vld_o,
	input  wire logic            stall_i,
	output cmta_pkg::out_t       dat_o
);

	logic vld_s1, vld_s2, ld_s1, ld_s2;
	logic [SW-1:0] col_s1, row_s1, size_s1;
	cmta_pkg::ctl_t ctl_s1;
	logic [2*SW:0] ofs_c;
	cmta_pkg::out_t dat_s2;

	assign ld_s2 = !vld_s2 || !stall_i;
	assign ld_s1 = !vld_s1 || ld_s2;
	assign rdy_o = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (ld_s1) begin
				vld_s1 <= vld_i;
			end
			if (ld_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// coordinate equal to size comes from a component equal to the magnitude
	always_ff @(posedge clk) begin
		if (ld_s1) begin
			size_s1 <= size_i;
			ctl_s1  <= ctl_i;
			if (ctl_i.zero) begin
				col_s1 <= '0;
				row_s1 <= '0;
			end else begin
				col_s1 <= (qu_i >= size_i) ? size_i - 1'b1 : qu_i;
				row_s1 <= (qv_i >= size_i) ? size_i - 1'b1 : qv_i;
			end
		end
	end

	assign ofs_c = (2*SW+1)'(row_s1) * (2*SW+1)'(size_s1) + (2*SW+1)'(col_s1);

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			dat_s2.face_index   <= ctl_s1.face;
			dat_s2.texel_col    <= cmta_pkg::COL_W'(col_s1);
			dat_s2.texel_row    <= cmta_pkg::COL_W'(row_s1);
			dat_s2.texel_offset <= cmta_pkg::OFS_W'(ofs_c);
			dat_s2.zero_vector  <= ctl_s1.zero;
		end
	end

	assign vld_o = vld_s2;
	assign dat_o = dat_s2;

endmodule

`default_nettype wire
